// ===== rtl/core/sobel_nonmax_edge_thinning_unit_macros.svh =====
// assertion macros for the sobel edge thinning unit
`ifndef SOBEL_NONMAX_EDGE_THINNING_UNIT_MACROS_SVH
`define SOBEL_NONMAX_EDGE_THINNING_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define SNET_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("snet assertion failed");
// condition that must never be seen out of reset
`define SNET_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("snet forbidden condition seen");
`else
`define SNET_ASSERT(name, prop)
`define SNET_NEVER(name, cond)
`endif
`endif

// ===== rtl/core/snet_pkg.sv =====
// shared types and constants of the sobel edge thinning unit
`timescale 1ns / 1ps
package snet_pkg;

  // sizes
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned MAG_W         = 21;
  localparam int unsigned DIR_W         = 2;
  localparam int unsigned IMG_W_W       = 11;
  localparam int unsigned IMG_H_W       = 13;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned ROW_W         = 14;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned ABS_W         = 10;
  localparam int unsigned SQ_W          = 20;
  localparam int unsigned CMP_W         = 28;
  localparam int unsigned FIFO_DEPTH    = 8;

  // reset sizes
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

  // tan(22.5) and tan(67.5) in 16-bit fraction
  localparam logic [CMP_W-1:0] TAN_LOW  = 28'd27146;
  localparam logic [CMP_W-1:0] TAN_HIGH = 28'd158218;

  // result codes
  localparam logic [PIX_W-1:0] EDGE_KEPT = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_NONE = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORIZ = 2'd0,
    DIR_DIAG  = 2'd1,
    DIR_VERT  = 2'd2,
    DIR_ANTI  = 2'd3
  } dir_e;

  // per word control carried down the pipeline
  typedef struct packed {
    logic             valid;
    logic             do_pix;
    logic             grad_ok;
    logic [PIX_W-1:0] pix;
    logic             do_mag;
    logic             do_out;
    logic             interior;
    logic             last;
  } ctl_t;

  // one queued result word
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             last;
  } res_t;

endpackage

// ===== rtl/core/snet_pix_if.sv =====
// pixel input channel
`timescale 1ns / 1ps
interface snet_pix_if import snet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             start_of_frame;
  logic             pad;

  modport source (output valid, pixel, start_of_frame, pad, input ready);
  modport sink (input valid, pixel, start_of_frame, pad, output ready);
endinterface

// ===== rtl/core/snet_res_if.sv =====
// edge result output channel
`timescale 1ns / 1ps
interface snet_res_if import snet_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic             last_of_frame;

  modport source (output valid, edge_value, last_of_frame, input ready);
  modport sink (input valid, edge_value, last_of_frame, output ready);
endinterface

// ===== rtl/core/snet_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module snet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sobel_nonmax_edge_thinning_unit.sv =====
// top level of the sobel edge thinning unit
`timescale 1ns / 1ps
`include "sobel_nonmax_edge_thinning_unit_macros.svh"
// Sobel gradient with non-maximum suppression on a raster stream of grey pixels.
// Input channel pix_i carries pixel, start_of_frame and pad with valid/ready;
// output channel res_o carries edge_value (255 kept, 0 suppressed or border)
// and last_of_frame. The user must write image width and height through
// cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle, unchecked.
// Throughput: one word per clock while ready is high, limited by the single
// write port of the pixel and magnitude rams (one read-modify-write per word).
// A result passes the pipeline registers s1_q to s4_q into the output queue
// and is offered on res_o from there; in stream terms a pixel's result follows
// 2*W+2 words later, so after the last pixel of a frame 2*W+2 more words
// (pad or not) flush it out.
// Reset clears counters, pipeline valids and the output queue; sizes return
// to 640 x 480. Line rams are not cleared, they are only read where written.
// When the receiver stalls, results gather in an 8-word output queue; the
// input drops ready once queued plus in-flight results would fill it.
module sobel_nonmax_edge_thinning_unit import snet_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  snet_pix_if.sink              pix_i,
  snet_res_if.source            res_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PMW   = 2 * PIX_W;
  localparam int unsigned MMW   = 2 * MAG_W + DIR_W;
  localparam int unsigned FAW   = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW   = $clog2(FIFO_DEPTH + 1);
  localparam logic [ROW_W-1:0] MAXW_X = ROW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] MAXH_X = ROW_W'(MAX_HEIGHT);

  // configuration registers
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= WIDTH_RESET;
      img_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [ROW_W-1:0] w_ext, h_ext, w_cl, h_eff, h_p1, h_p2;
  logic [WW-1:0]    w_eff;

  always_comb begin
    w_ext = ROW_W'(img_w_q);
    h_ext = ROW_W'(img_h_q);
    priority if (w_ext < ROW_W'(3)) w_cl = ROW_W'(3);
    else if (w_ext > MAXW_X)        w_cl = MAXW_X;
    else                            w_cl = w_ext;
    priority if (h_ext < ROW_W'(3)) h_eff = ROW_W'(3);
    else if (h_ext > MAXH_X)        h_eff = MAXH_X;
    else                            h_eff = h_ext;
    w_eff = w_cl[WW-1:0];
    h_p1  = h_eff + ROW_W'(1);
    h_p2  = h_eff + ROW_W'(2);
  end

  // position counters and word classification
  logic [CW-1:0]    col_q, col_d, cn, xs;
  logic [ROW_W-1:0] row_q, row_d, rn;
  logic             sof, wrap, row_lt_h, past, proceed, accept;
  ctl_t             ctl0;

  always_comb begin
    sof      = pix_i.start_of_frame;
    wrap     = !sof && (WW'(col_q) >= w_eff);
    cn       = (sof || wrap) ? '0 : col_q;
    rn       = sof ? '0 : (wrap ? row_q + ROW_W'(1) : row_q);
    row_lt_h = rn < h_eff;
    past     = (rn > h_p2) || ((rn == h_p2) && (cn >= CW'(2)));
    proceed  = sof || !(past || (pix_i.pad && row_lt_h));
    xs       = (cn == '0) ? CW'(w_eff - WW'(1)) : cn - CW'(1);

    ctl0.valid    = accept && proceed;
    ctl0.do_pix   = row_lt_h;
    ctl0.grad_ok  = row_lt_h && (rn >= ROW_W'(2)) && (cn >= CW'(2));
    ctl0.pix      = pix_i.pixel;
    ctl0.do_mag   = (rn >= ROW_W'(2)) || ((rn == ROW_W'(1)) && (cn >= CW'(1)));
    ctl0.do_out   = (rn >= ROW_W'(3)) || ((rn == ROW_W'(2)) && (cn >= CW'(2)));
    ctl0.interior = ((cn >= CW'(3)) && (rn >= ROW_W'(3)) && (rn <= h_eff)) ||
                    ((cn == '0) && (rn >= ROW_W'(4)) && (rn <= h_p1));
    ctl0.last     = (rn == h_p2) && (cn == CW'(1));

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (!proceed) begin
        col_d = cn;
        row_d = rn;
      end else if ((WW'(cn) + WW'(1)) >= w_eff) begin
        col_d = '0;
        row_d = rn + ROW_W'(1);
      end else begin
        col_d = cn + CW'(1);
        row_d = rn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // pipeline control
  ctl_t          s1_q, s2_q, s3_q, s4_q;
  logic [CW-1:0] col1_q, xs1_q, xs2_q, xs3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else begin
      s1_q <= ctl0;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q <= cn;
    xs1_q  <= xs;
    xs2_q  <= xs1_q;
    xs3_q  <= xs2_q;
  end

  // pixel line ram: each entry holds the two rows above at that column
  logic [PMW-1:0]   pix_rd;
  logic [PIX_W-1:0] pa, pb;

  snet_ram #(
    .WIDTH (PMW),
    .DEPTH (MAX_WIDTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q.valid && s1_q.do_pix),
    .waddr_i (col1_q),
    .wdata_i ({pb, s1_q.pix}),
    .re_i    (ctl0.valid && ctl0.do_pix),
    .raddr_i (cn),
    .rdata_o (pix_rd)
  );

  assign pa = pix_rd[PMW-1:PIX_W];
  assign pb = pix_rd[PIX_W-1:0];

  // pixel window shift and sobel sums
  logic [PIX_W-1:0]         win_q [9];
  logic [PIX_W-1:0]         nw [9];
  logic [PIX_W+1:0]         sum_r, sum_l, sum_d, sum_u;
  logic signed [GRAD_W-1:0] gx, gy, gx2_q, gy2_q;

  always_comb begin
    nw[0] = win_q[1];
    nw[1] = win_q[2];
    nw[2] = pa;
    nw[3] = win_q[4];
    nw[4] = win_q[5];
    nw[5] = pb;
    nw[6] = win_q[7];
    nw[7] = win_q[8];
    nw[8] = s1_q.pix;
    sum_r = (PIX_W+2)'(nw[2]) + {1'b0, nw[5], 1'b0} + (PIX_W+2)'(nw[8]);
    sum_l = (PIX_W+2)'(nw[0]) + {1'b0, nw[3], 1'b0} + (PIX_W+2)'(nw[6]);
    sum_d = (PIX_W+2)'(nw[6]) + {1'b0, nw[7], 1'b0} + (PIX_W+2)'(nw[8]);
    sum_u = (PIX_W+2)'(nw[0]) + {1'b0, nw[1], 1'b0} + (PIX_W+2)'(nw[2]);
    gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy    = $signed({1'b0, sum_d}) - $signed({1'b0, sum_u});
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid && s1_q.do_pix) begin
      win_q <= nw;
    end
    gx2_q <= gx;
    gy2_q <= gy;
  end

  // absolute values and squares
  logic [ABS_W-1:0] ax, ay, ax3_q, ay3_q;
  logic [SQ_W-1:0]  sqx3_q, sqy3_q;
  logic             same3_q;

  always_comb begin
    ax = gx2_q[GRAD_W-1] ? ABS_W'(-gx2_q) : ABS_W'(gx2_q);
    ay = gy2_q[GRAD_W-1] ? ABS_W'(-gy2_q) : ABS_W'(gy2_q);
  end

  always_ff @(posedge clk_i) begin
    ax3_q   <= ax;
    ay3_q   <= ay;
    sqx3_q  <= SQ_W'(ax) * SQ_W'(ax);
    sqy3_q  <= SQ_W'(ay) * SQ_W'(ay);
    same3_q <= (gx2_q[GRAD_W-1] == gy2_q[GRAD_W-1]);
  end

  // magnitude line ram: two rows of magnitude plus the newer direction
  logic [MMW-1:0]   mag_rd;
  logic [MAG_W-1:0] m_old, m_new, mag, mag_new;
  logic [CMP_W-1:0] ay_sh, lim_lo, lim_hi;
  dir_e             sec, dir_new, d_rd, d_hold_q, d4_q;

  snet_ram #(
    .WIDTH (MMW),
    .DEPTH (MAX_WIDTH)
  ) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (s3_q.valid && s3_q.do_mag),
    .waddr_i (xs3_q),
    .wdata_i ({m_new, mag_new, dir_new}),
    .re_i    (s2_q.valid && s2_q.do_mag),
    .raddr_i (xs2_q),
    .rdata_o (mag_rd)
  );

  // magnitude sum and direction sector
  always_comb begin
    m_old  = mag_rd[MMW-1:MAG_W+DIR_W];
    m_new  = mag_rd[MAG_W+DIR_W-1:DIR_W];
    d_rd   = dir_e'(mag_rd[DIR_W-1:0]);
    mag    = MAG_W'(sqx3_q) + MAG_W'(sqy3_q);
    ay_sh  = {CMP_W'(ay3_q)} << 16;
    lim_lo = CMP_W'(ax3_q) * TAN_LOW;
    lim_hi = CMP_W'(ax3_q) * TAN_HIGH;
    priority if ((ax3_q == '0) && (ay3_q == '0)) sec = DIR_HORIZ;
    else if (ay_sh < lim_lo)                     sec = DIR_HORIZ;
    else if (ay_sh >= lim_hi)                    sec = DIR_VERT;
    else if (same3_q)                            sec = DIR_DIAG;
    else                                         sec = DIR_ANTI;
    mag_new = s3_q.grad_ok ? mag : '0;
    dir_new = s3_q.grad_ok ? sec : DIR_HORIZ;
  end

  // magnitude window and direction of the left neighbor column
  logic [MAG_W-1:0] mw_q [9];

  always_ff @(posedge clk_i) begin
    if (s3_q.valid && s3_q.do_mag) begin
      mw_q[0]  <= mw_q[1];
      mw_q[1]  <= mw_q[2];
      mw_q[2]  <= m_old;
      mw_q[3]  <= mw_q[4];
      mw_q[4]  <= mw_q[5];
      mw_q[5]  <= m_new;
      mw_q[6]  <= mw_q[7];
      mw_q[7]  <= mw_q[8];
      mw_q[8]  <= mag_new;
      d_hold_q <= d_rd;
    end
    d4_q <= d_hold_q;
  end

  // suppression against the two neighbors along the gradient
  logic [MAG_W-1:0] n1, n2;
  logic [PIX_W-1:0] val;
  logic             push;

  always_comb begin
    unique case (d4_q)
      DIR_HORIZ: begin n1 = mw_q[3]; n2 = mw_q[5]; end
      DIR_DIAG:  begin n1 = mw_q[0]; n2 = mw_q[8]; end
      DIR_VERT:  begin n1 = mw_q[1]; n2 = mw_q[7]; end
      DIR_ANTI:  begin n1 = mw_q[2]; n2 = mw_q[6]; end
      default:   begin n1 = mw_q[3]; n2 = mw_q[5]; end
    endcase
    if (!s4_q.interior || (mw_q[4] < n1) || (mw_q[4] < n2)) begin
      val = EDGE_NONE;
    end else begin
      val = EDGE_KEPT;
    end
    push = s4_q.valid && s4_q.do_out;
  end

  // output queue
  res_t           fifo_q [FIFO_DEPTH];
  logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCW-1:0] cnt_q;
  logic           pop;
  logic [2:0]     pend;
  logic [FCW:0]   credit;

  always_comb begin
    pop    = res_o.valid && res_o.ready;
    pend   = 3'(s1_q.valid && s1_q.do_out) + 3'(s2_q.valid && s2_q.do_out) +
             3'(s3_q.valid && s3_q.do_out) + 3'(s4_q.valid && s4_q.do_out);
    credit = (FCW+1)'(cnt_q) + (FCW+1)'(pend);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{edge_value: val, last: s4_q.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FAW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + FAW'(1);
      cnt_q <= cnt_q + FCW'(push) - FCW'(pop);
    end
  end

  // channel handshakes
  assign pix_i.ready         = credit < (FCW+1)'(FIFO_DEPTH);
  assign accept              = pix_i.valid && pix_i.ready;
  assign res_o.valid         = cnt_q != '0;
  assign res_o.edge_value    = fifo_q[rd_ptr_q].edge_value;
  assign res_o.last_of_frame = fifo_q[rd_ptr_q].last;

  // checks
  `SNET_NEVER(a_fifo_no_overflow, push && !pop && (cnt_q == FCW'(FIFO_DEPTH)))
  `SNET_ASSERT(a_credit_bound, credit <= (FCW+1)'(FIFO_DEPTH))
  `SNET_ASSERT(a_edge_legal, res_o.valid |-> (res_o.edge_value == EDGE_NONE || res_o.edge_value == EDGE_KEPT))
  `SNET_NEVER(a_last_is_border, res_o.valid && res_o.last_of_frame && (res_o.edge_value != EDGE_NONE))

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench of the sobel edge thinning unit
`timescale 1ns / 1ps
module tb;
  import snet_pkg::*;

  localparam int unsigned MAXW = MAX_WIDTH_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  snet_pix_if pix_if ();
  snet_res_if res_if ();

  sobel_nonmax_edge_thinning_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .pix_i(pix_if.sink), .res_o(res_if.source)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  logic [PIX_W-1:0] pix_store [2*MAXW];
  logic [MAG_W-1:0] mag_store [2*MAXW];
  logic [DIR_W-1:0] dir_store [2*MAXW];
  logic [PIX_W-1:0] pwin [9];
  logic [MAG_W-1:0] mwin [9];
  int unsigned col_cnt, row_cnt;

  res_t edge_queue [$];
  int unsigned mism = 0;
  int unsigned stall_cycles = 0;
  logic sink_hold = 1'b0;

  function automatic logic [DIR_W-1:0] sector(int gx, int gy);
    longint unsigned ax, ay;
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    if (ax == 0 && ay == 0) return DIR_HORIZ;
    if (ay * 65536 < longint'(TAN_LOW) * ax) return DIR_HORIZ;
    if (ay * 65536 >= longint'(TAN_HIGH) * ax) return DIR_VERT;
    return ((gx < 0) == (gy < 0)) ? DIR_DIAG : DIR_ANTI;
  endfunction

  // one predictor step per accepted word
  task automatic predict_word(logic [PIX_W-1:0] v, logic sof, logic pad);
    longint unsigned w, h, p, lim, s, q, qy, qx;
    int unsigned ys, xs, cs, ps, os, pvs;
    logic [MAG_W-1:0] mnew, m0, m1, c, n1, n2;
    logic [DIR_W-1:0] dnew, d;
    logic [PIX_W-1:0] a, b;
    int gx, gy;
    res_t r;
    w = (width_reg < 3) ? 3 : (width_reg > MAXW ? MAXW : width_reg);
    h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    mnew = '0;
    dnew = DIR_HORIZ;
    if (sof) begin
      col_cnt = 0; row_cnt = 0;
    end else if (col_cnt >= w) begin
      col_cnt = 0; row_cnt++;
    end
    p = longint'(row_cnt) * w + col_cnt;
    lim = h * w + 2 * w + 2;
    if (!sof && (p >= lim || (pad && row_cnt < h))) return;
    if (row_cnt < h) begin
      os = (row_cnt & 1) * MAXW;
      pvs = ((row_cnt + 1) & 1) * MAXW;
      a = pix_store[os + col_cnt];
      b = pix_store[pvs + col_cnt];
      pix_store[os + col_cnt] = v;
      for (int k = 0; k < 3; k++) begin
        pwin[k*3] = pwin[k*3+1]; pwin[k*3+1] = pwin[k*3+2];
      end
      pwin[2] = a; pwin[5] = b; pwin[8] = v;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        gx = (pwin[2] + 2*pwin[5] + pwin[8]) - (pwin[0] + 2*pwin[3] + pwin[6]);
        gy = (pwin[6] + 2*pwin[7] + pwin[8]) - (pwin[0] + 2*pwin[1] + pwin[2]);
        mnew = MAG_W'(gx*gx + gy*gy);
        dnew = sector(gx, gy);
      end
    end
    if (p >= w + 1) begin
      s = p - w - 1;
      ys = 32'(s / w); xs = 32'(s % w);
      cs = (ys & 1) * MAXW; ps = ((ys + 1) & 1) * MAXW;
      m0 = mag_store[cs + xs]; m1 = mag_store[ps + xs];
      mag_store[cs + xs] = mnew;
      dir_store[cs + xs] = dnew;
      for (int k = 0; k < 3; k++) begin
        mwin[k*3] = mwin[k*3+1]; mwin[k*3+1] = mwin[k*3+2];
      end
      mwin[2] = m0; mwin[5] = m1; mwin[8] = mnew;
      if (s >= w + 1) begin
        q = s - w - 1;
        if (q < h * w) begin
          qy = q / w; qx = q % w;
          r.edge_value = EDGE_NONE;
          if (qy >= 1 && qy + 2 <= h && qx >= 1 && qx + 2 <= w) begin
            d = dir_store[ps + xs - 1];
            c = mwin[4];
            case (d)
              DIR_HORIZ: begin n1 = mwin[3]; n2 = mwin[5]; end
              DIR_DIAG:  begin n1 = mwin[0]; n2 = mwin[8]; end
              DIR_VERT:  begin n1 = mwin[1]; n2 = mwin[7]; end
              default:   begin n1 = mwin[2]; n2 = mwin[6]; end
            endcase
            r.edge_value = (c < n1 || c < n2) ? EDGE_NONE : EDGE_KEPT;
          end
          r.last = (q == h * w - 1);
          edge_queue.push_back(r);
        end
      end
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0; row_cnt++;
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // send one word, with a random gap in front
  task automatic send_word(logic [PIX_W-1:0] v, logic sof, logic pad, bit gaps = 1);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      pix_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= v;
    pix_if.start_of_frame <= sof;
    pix_if.pad <= pad;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_word(v, sof, pad);
  endtask

  task automatic go_idle();
    pix_if.valid <= 1'b0;
    while (edge_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val[IMG_W_W-1:0];
    else height_reg = val;
  endtask

  // pixel pattern: 0 random, 1 step edge, 2 extremes checker
  task automatic send_frame(int unsigned w, int unsigned h, int unsigned kind,
                            bit pad_flush, bit noise);
    logic [PIX_W-1:0] v;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        case (kind)
          0: v = PIX_W'($urandom_range(0, 255));
          1: v = (x + y > (w + h) / 2) ? 8'hff : 8'h00;
          default: v = ((x ^ y) & 1) ? 8'hff : 8'h00;
        endcase
        if (noise && $urandom_range(0, 9) == 0)
          send_word(PIX_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        send_word(v, (x == 0 && y == 0), (x == 0 && y == 0) ? noise : 1'b0);
      end
    end
    for (int unsigned k = 0; k < 2 * w + 2; k++)
      send_word(PIX_W'($urandom_range(0, 255)), 1'b0,
                pad_flush ? 1'b1 : 1'($urandom_range(0, 1)));
    if (noise) begin
      repeat (3) send_word(PIX_W'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (edge_queue.size() == 0) begin
        mism++;
        if (mism <= 10) $display("tb: unexpected result word %0d", res_if.edge_value);
      end else begin
        if (res_if.edge_value !== edge_queue[0].edge_value ||
            res_if.last_of_frame !== edge_queue[0].last) begin
          mism++;
          if (mism <= 10)
            $display("tb: mismatch exp edge %0d last %0b got edge %0d last %0b",
                     edge_queue[0].edge_value, edge_queue[0].last,
                     res_if.edge_value, res_if.last_of_frame);
        end
        void'(edge_queue.pop_front());
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned g;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold) res_if.ready <= 1'b1;
      else begin
        g = gap_len();
        res_if.ready <= (g == 0);
        if (g != 0) repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no accepted word and no taken result
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || !rst_ni)
      stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic test_reset_size();
    // default 640x480 would be long; shrink first then test minimum frame
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    send_frame(3, 3, 2, 1'b1, 1'b0);
    go_idle();
  endtask

  task automatic test_directed();
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    send_frame(3, 3, 1, 1'b0, 1'b0);
    go_idle();
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_IMAGE_HEIGHT, 4);
    send_frame(5, 4, 2, 1'b1, 1'b1);
    go_idle();
  endtask

  task automatic test_wide_frame();
    // long rows, fewest lines
    write_reg(CFG_IMAGE_WIDTH, 100);
    write_reg(CFG_IMAGE_HEIGHT, 3);
    send_frame(100, 3, 0, 1'b0, 1'b0);
    go_idle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    for (int n = 0; n < 18; n++) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      send_frame(w, h, $urandom_range(0, 2), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 3) == 0));
      if (n == 6) sink_hold = 1'b1;
      if (n == 12) sink_hold = 1'b0;
      go_idle();
    end
  endtask

  task automatic test_tall_frame();
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 40);
    send_frame(3, 40, 0, 1'b1, 1'b0);
    go_idle();
  endtask

  initial begin
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col_cnt = 0; row_cnt = 0;
    for (int k = 0; k < 9; k++) begin
      pwin[k] = '0; mwin[k] = '0;
    end
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.start_of_frame = 1'b0;
    pix_if.pad = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_size();
    test_directed();
    test_random_frames();
    test_wide_frame();
    test_tall_frame();
    go_idle();
    if (mism == 0 && edge_queue.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
